### hw/rtl/udp_rc_pkg.sv
// Shared constants, types and helpers for the UDP receive checker.
package udp_rc_pkg;

    localparam int NUM_PORT_ENTRIES = 4;
    localparam int PORT_STORE       = 4;
    localparam int SEARCH_ENTRIES   = (NUM_PORT_ENTRIES < PORT_STORE) ?
                                      NUM_PORT_ENTRIES : PORT_STORE;
    localparam int ENTRY_IDX_W      = 2;
    localparam int PORT_ENTRY_W     = 17;
    localparam int PORT_VALID_BIT   = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int SUM_W            = 19;

    localparam logic [15:0] UDP_PROTO   = 16'd17;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LAST = 3'd4;

    typedef enum logic [1:0] {
        VERDICT_DELIVER = 2'd0,
        VERDICT_UNREACH = 2'd1,
        VERDICT_BAD_SUM = 2'd2,
        VERDICT_SHORT   = 2'd3
    } t_verdict;

    // Snapshot of one datagram, taken at its last byte.
    typedef struct packed {
        logic        short_dgram;
        logic [15:0] running_sum;
        logic [7:0]  high_byte_hold;
        logic [31:0] sender_ip;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] udp_length;
        logic [15:0] checksum;
    } t_dgram_rec;

    // 16-bit ones'-complement add; a second end-around carry cannot occur.
    function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

### hw/rtl/udp_rc_in_if.sv
// Byte stream channel carrying received UDP datagram bytes.
interface udp_rc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] sender_ip;

    modport source (output valid, data_byte, last_byte, sender_ip, input ready);
    modport sink   (input valid, data_byte, last_byte, sender_ip, output ready);
endinterface

### hw/rtl/udp_rc_out_if.sv
// Result channel carrying one verdict per datagram.
interface udp_rc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [1:0]  entry_index;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] udp_length;

    modport source (output valid, verdict, entry_index, source_port, destination_port,
                    udp_length, input ready);
    modport sink   (input valid, verdict, entry_index, source_port, destination_port,
                    udp_length, output ready);
endinterface

### hw/rtl/udp_rc_accum.sv
// Per-byte header capture and running ones'-complement sum.
module udp_rc_accum (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    input  logic [31:0]            i_sender_ip,
    output udp_rc_pkg::t_dgram_rec o_rec
);

    logic [15:0] r_byte_count;
    logic [15:0] r_running_sum;
    logic [7:0]  r_high_byte_hold;
    logic [31:0] r_sender_ip;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;
    logic [15:0] r_length;
    logic [15:0] r_checksum;

    logic [15:0] n_byte_count;
    logic [15:0] n_running_sum;
    logic [7:0]  n_high_byte_hold;
    logic [31:0] n_sender_ip;
    logic [15:0] n_src_port;
    logic [15:0] n_dst_port;
    logic [15:0] n_length;
    logic [15:0] n_checksum;

    logic        hdr;
    logic        included;
    logic [7:0]  sum_byte;
    logic [16:0] total;

    always_comb begin
        n_running_sum    = r_running_sum;
        n_high_byte_hold = r_high_byte_hold;
        n_sender_ip      = r_sender_ip;
        n_src_port       = r_src_port;
        n_dst_port       = r_dst_port;
        n_length         = r_length;
        n_checksum       = r_checksum;

        hdr = (r_byte_count[15:3] == 13'd0);
        if (r_byte_count == 16'd0) begin
            n_sender_ip = i_sender_ip;
        end
        if (hdr) begin
            case (r_byte_count[2:0])
                3'd0: n_src_port = {i_data_byte, 8'h00};
                3'd1: n_src_port = {r_src_port[15:8], i_data_byte};
                3'd2: n_dst_port = {i_data_byte, 8'h00};
                3'd3: n_dst_port = {r_dst_port[15:8], i_data_byte};
                3'd4: n_length   = {i_data_byte, 8'h00};
                3'd5: n_length   = {r_length[15:8], i_data_byte};
                3'd6: n_checksum = {i_data_byte, 8'h00};
                3'd7: n_checksum = {r_checksum[15:8], i_data_byte};
                default: ;
            endcase
        end

        // checksum field bytes count as zero
        included = hdr || (r_byte_count < r_length);
        sum_byte = (hdr && (r_byte_count[2:1] == 2'b11)) ? 8'h00 : i_data_byte;
        if (included) begin
            if (!r_byte_count[0]) begin
                n_high_byte_hold = sum_byte;
            end else begin
                n_running_sum = udp_rc_pkg::oc_add(r_running_sum,
                                                   {r_high_byte_hold, sum_byte});
            end
        end

        n_byte_count = (r_byte_count == 16'hFFFF) ? r_byte_count : r_byte_count + 16'd1;

        total = {1'b0, r_byte_count} + 17'd1;
        o_rec.short_dgram      = (total < {1'b0, udp_rc_pkg::UDP_HDR_LEN}) ||
                                 (n_length < udp_rc_pkg::UDP_HDR_LEN) ||
                                 (total < {1'b0, n_length});
        o_rec.running_sum      = n_running_sum;
        o_rec.high_byte_hold   = n_high_byte_hold;
        o_rec.sender_ip        = n_sender_ip;
        o_rec.source_port      = n_src_port;
        o_rec.destination_port = n_dst_port;
        o_rec.udp_length       = n_length;
        o_rec.checksum         = n_checksum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_byte_count     <= '0;
            r_running_sum    <= '0;
            r_high_byte_hold <= '0;
            r_sender_ip      <= '0;
            r_src_port       <= '0;
            r_dst_port       <= '0;
            r_length         <= '0;
            r_checksum       <= '0;
        end else if (i_take) begin
            r_byte_count     <= n_byte_count;
            r_running_sum    <= n_running_sum;
            r_high_byte_hold <= n_high_byte_hold;
            r_sender_ip      <= n_sender_ip;
            r_src_port       <= n_src_port;
            r_dst_port       <= n_dst_port;
            r_length         <= n_length;
            r_checksum       <= n_checksum;
        end
    end

endmodule

### hw/rtl/udp_rc_verdict.sv
// Pseudo header sum, checksum compare, port lookup and result register.
module udp_rc_verdict (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rec_load,
    input  udp_rc_pkg::t_dgram_rec i_rec,
    input  logic [31:0]            i_local_ip,
    input  logic [udp_rc_pkg::PORT_STORE-1:0][udp_rc_pkg::PORT_ENTRY_W-1:0] i_port_entry,
    output logic                   o_can_take,
    udp_rc_out_if.source           o_out
);

    logic                   en_a, en_b, en_o;

    logic                   r_a_valid;
    udp_rc_pkg::t_dgram_rec r_a;

    logic                   r_b_valid;
    udp_rc_pkg::t_dgram_rec r_b;
    logic [udp_rc_pkg::SUM_W-1:0] r_b_sum;
    logic [udp_rc_pkg::SUM_W-1:0] n_b_sum;

    logic                   r_o_valid;
    udp_rc_pkg::t_verdict   r_o_verdict;
    logic [udp_rc_pkg::ENTRY_IDX_W-1:0] r_o_entry;
    logic [15:0]            r_o_src, r_o_dst, r_o_len;

    udp_rc_pkg::t_verdict   n_verdict;
    logic [udp_rc_pkg::ENTRY_IDX_W-1:0] n_entry;
    logic [16:0]            fold1;
    logic [15:0]            fold2;
    logic [15:0]            calc;
    logic                   hit;
    logic [udp_rc_pkg::ENTRY_IDX_W-1:0] hit_idx;

    assign en_o       = !r_o_valid || o_out.ready;
    assign en_b       = !r_b_valid || en_o;
    assign en_a       = !r_a_valid || en_b;
    assign o_can_take = en_a;

    // Eight-operand sum; folded to ones' complement in the next stage.
    always_comb begin
        n_b_sum = {3'b0, r_a.running_sum}
                + (r_a.udp_length[0] ? {3'b0, r_a.high_byte_hold, 8'h00} : '0)
                + {3'b0, r_a.sender_ip[31:16]}
                + {3'b0, r_a.sender_ip[15:0]}
                + {3'b0, i_local_ip[31:16]}
                + {3'b0, i_local_ip[15:0]}
                + {3'b0, udp_rc_pkg::UDP_PROTO}
                + {3'b0, r_a.udp_length};
    end

    always_comb begin
        fold1 = {1'b0, r_b_sum[15:0]} + {14'b0, r_b_sum[18:16]};
        fold2 = fold1[15:0] + {15'b0, fold1[16]};
        calc  = ~fold2;
        if (calc == 16'h0000) begin
            calc = 16'hFFFF;
        end

        // descending scan so the lowest matching entry wins
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = udp_rc_pkg::SEARCH_ENTRIES - 1; i >= 0; i--) begin
            if (i_port_entry[i][udp_rc_pkg::PORT_VALID_BIT] &&
                (i_port_entry[i][15:0] == r_b.destination_port)) begin
                hit     = 1'b1;
                hit_idx = udp_rc_pkg::ENTRY_IDX_W'(i);
            end
        end

        n_entry = '0;
        if (r_b.short_dgram) begin
            n_verdict = udp_rc_pkg::VERDICT_SHORT;
        end else if ((r_b.checksum != 16'h0000) && (r_b.checksum != calc)) begin
            n_verdict = udp_rc_pkg::VERDICT_BAD_SUM;
        end else if (hit) begin
            n_verdict = udp_rc_pkg::VERDICT_DELIVER;
            n_entry   = hit_idx;
        end else begin
            n_verdict = udp_rc_pkg::VERDICT_UNREACH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_rec_load;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (en_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_rec_load) begin
            r_a <= i_rec;
        end
        if (en_b && r_a_valid) begin
            r_b     <= r_a;
            r_b_sum <= n_b_sum;
        end
        if (en_o && r_b_valid) begin
            r_o_verdict <= n_verdict;
            r_o_entry   <= n_entry;
            r_o_src     <= r_b.source_port;
            r_o_dst     <= r_b.destination_port;
            r_o_len     <= r_b.udp_length;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.verdict          = r_o_verdict;
    assign o_out.entry_index      = r_o_entry;
    assign o_out.source_port      = r_o_src;
    assign o_out.destination_port = r_o_dst;
    assign o_out.udp_length       = r_o_len;

endmodule

### hw/rtl/udp_receive_check_and_port_demux.sv
// Top level: UDP receive checksum verify and destination port demux.
//
// Input channel i_in carries one datagram byte per transfer, header first,
// with last_byte on the final byte; sender_ip is sampled with the first byte.
// Output channel o_out carries one verdict per datagram: deliver (with the
// matching port entry), port unreachable, checksum mismatch or too short,
// plus the source port, destination port and length from the header.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 local_ip, 1..4 port entries: bit 16 valid, bits 15..0 port);
// other indexes are ignored. Write only while no datagram is in flight.
// Throughput: one byte per clock while i_in.ready is high; the accumulator
// keeps each even byte and adds each byte pair as a ones'-complement word.
// o_out.valid rises after the last byte's transfer has passed the registered
// stages snapshot, pseudo header sum and fold/compare/lookup register.
// Stall: up to three finished datagrams queue in the stages; i_in.ready
// drops only when all three are full behind a stalled o_out.
// Reset clears the registers, the byte state and all stage valid bits.
module udp_receive_check_and_port_demux (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [udp_rc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [udp_rc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    udp_rc_in_if.sink                        i_in,
    udp_rc_out_if.source                     o_out
);

    logic [31:0] r_local_ip;
    logic [udp_rc_pkg::PORT_STORE-1:0][udp_rc_pkg::PORT_ENTRY_W-1:0] r_port_entry;

    logic                   take;
    logic                   can_take;
    udp_rc_pkg::t_dgram_rec rec;
    logic [udp_rc_pkg::CFG_IDX_W-1:0] port_sel;

    assign port_sel = i_cfg_index - udp_rc_pkg::CFG_PORT_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip   <= '0;
            r_port_entry <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == udp_rc_pkg::CFG_LOCAL_IP) begin
                r_local_ip <= i_cfg_data[31:0];
            end else if ((i_cfg_index >= udp_rc_pkg::CFG_PORT_0) &&
                         (i_cfg_index <= udp_rc_pkg::CFG_PORT_LAST)) begin
                r_port_entry[port_sel[udp_rc_pkg::ENTRY_IDX_W-1:0]] <=
                    i_cfg_data[udp_rc_pkg::PORT_ENTRY_W-1:0];
            end
        end
    end

    assign i_in.ready = can_take;
    assign take       = i_in.valid && can_take;

    udp_rc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_sender_ip (i_in.sender_ip),
        .o_rec       (rec)
    );

    udp_rc_verdict u_verdict (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_load   (take && i_in.last_byte),
        .i_rec        (rec),
        .i_local_ip   (r_local_ip),
        .i_port_entry (r_port_entry),
        .o_can_take   (can_take),
        .o_out        (o_out)
    );

`ifndef NO_ASSERTIONS
    a_deliver_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.verdict == udp_rc_pkg::VERDICT_DELIVER)) |->
        (r_port_entry[o_out.entry_index][udp_rc_pkg::PORT_VALID_BIT] &&
         (r_port_entry[o_out.entry_index][15:0] == o_out.destination_port)))
        else $error("deliver verdict without a matching valid port entry");

    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.verdict != udp_rc_pkg::VERDICT_DELIVER)) |->
        (o_out.entry_index == '0))
        else $error("entry index set on a non-deliver verdict");

    a_len_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.verdict != udp_rc_pkg::VERDICT_SHORT)) |->
        (o_out.udp_length >= udp_rc_pkg::UDP_HDR_LEN))
        else $error("length below header size passed the length check");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled while the output stage can move");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the UDP receive checker and port demux.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 215;

    // index outside the register map, must be ignored
    localparam logic [udp_rc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum int {
        SUM_GOOD,
        SUM_NONE,
        SUM_BAD,
        SUM_FOLDS_TO_ZERO
    } t_sum_style;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [31:0] sip;
        bit          drain;
    } t_byte_xfer;

    typedef struct {
        udp_rc_pkg::t_verdict verdict;
        logic [1:0]  entry;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] len;
    } t_verdict_rec;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [udp_rc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [udp_rc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    udp_rc_in_if  in_ch ();
    udp_rc_out_if out_ch ();

    udp_receive_check_and_port_demux u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_byte_xfer   byte_backlog[$];
    t_verdict_rec pending_verdicts[$];
    logic [7:0]   frame_bytes[$];

    int bytes_queued = 0;
    int bytes_taken  = 0;
    int mismatches   = 0;
    int cycles       = 0;
    int hold_left    = 0;
    bit hold_request = 0;
    bit tx_gaps_on   = 1;
    bit rx_gaps_on   = 1;

    // register mirror
    logic [31:0]                         cfg_local_ip = '0;
    logic [udp_rc_pkg::PORT_ENTRY_W-1:0] cfg_entry[udp_rc_pkg::PORT_STORE] = '{default: '0};

    // per-datagram state of the predictor
    logic [15:0] dg_count  = '0;
    logic [15:0] dg_sum    = '0;
    logic [7:0]  dg_hi     = '0;
    logic [31:0] dg_src_ip = '0;
    logic [15:0] dg_sport  = '0;
    logic [15:0] dg_dport  = '0;
    logic [15:0] dg_len    = '0;
    logic [15:0] dg_cksum  = '0;

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] oc16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // Advances the predictor by one accepted byte; queues a verdict on the last one.
    function automatic void absorb_byte(input logic [7:0] b, input logic last,
                                        input logic [31:0] sip);
        logic [15:0]  idx;
        logic [15:0]  s;
        logic [15:0]  calc;
        logic [7:0]   v;
        int           total;
        t_verdict_rec r;
        idx = dg_count;
        if (idx == 16'd0) dg_src_ip = sip;
        case (idx)
            16'd0: dg_sport = {b, 8'h00};
            16'd1: dg_sport[7:0] = b;
            16'd2: dg_dport = {b, 8'h00};
            16'd3: dg_dport[7:0] = b;
            16'd4: dg_len = {b, 8'h00};
            16'd5: dg_len[7:0] = b;
            16'd6: dg_cksum = {b, 8'h00};
            16'd7: dg_cksum[7:0] = b;
            default: ;
        endcase
        if (idx < udp_rc_pkg::UDP_HDR_LEN || idx < dg_len) begin
            // checksum field counts as zero
            v = (idx == 16'd6 || idx == 16'd7) ? 8'h00 : b;
            if (!idx[0]) dg_hi = v;
            else dg_sum = oc16(dg_sum, {dg_hi, v});
        end
        if (dg_count != 16'hFFFF) dg_count = dg_count + 16'd1;
        if (!last) return;

        total = int'(idx) + 1;
        r.entry = '0;
        r.sport = dg_sport;
        r.dport = dg_dport;
        r.len   = dg_len;
        if (total < 8 || dg_len < udp_rc_pkg::UDP_HDR_LEN || total < int'(dg_len)) begin
            r.verdict = udp_rc_pkg::VERDICT_SHORT;
        end else begin
            s = dg_sum;
            if (dg_len[0]) s = oc16(s, {dg_hi, 8'h00});
            s = oc16(s, dg_src_ip[31:16]);
            s = oc16(s, dg_src_ip[15:0]);
            s = oc16(s, cfg_local_ip[31:16]);
            s = oc16(s, cfg_local_ip[15:0]);
            s = oc16(s, udp_rc_pkg::UDP_PROTO);
            s = oc16(s, dg_len);
            calc = ~s;
            if (calc == 16'd0) calc = 16'hFFFF;
            if (dg_cksum != 16'd0 && dg_cksum != calc) begin
                r.verdict = udp_rc_pkg::VERDICT_BAD_SUM;
            end else begin
                r.verdict = udp_rc_pkg::VERDICT_UNREACH;
                // walk down so the lowest matching entry wins
                for (int i = udp_rc_pkg::SEARCH_ENTRIES - 1; i >= 0; i--) begin
                    if (cfg_entry[i][udp_rc_pkg::PORT_VALID_BIT] &&
                        cfg_entry[i][15:0] == dg_dport) begin
                        r.verdict = udp_rc_pkg::VERDICT_DELIVER;
                        r.entry   = udp_rc_pkg::ENTRY_IDX_W'(i);
                    end
                end
            end
        end
        pending_verdicts.push_back(r);
        dg_count  = '0;
        dg_sum    = '0;
        dg_hi     = '0;
        dg_src_ip = '0;
        dg_sport  = '0;
        dg_dport  = '0;
        dg_len    = '0;
        dg_cksum  = '0;
    endfunction

    // Byte sender
    always @(posedge i_clk) begin : drive_bytes
        t_byte_xfer nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_byte(in_ch.data_byte, in_ch.last_byte, in_ch.sender_ip);
                bytes_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (byte_backlog.size() != 0 && !(tx_gaps_on && $urandom_range(99) < 12)
                    && !(byte_backlog[0].drain && pending_verdicts.size() != 0)) begin
                    nxt = byte_backlog.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= nxt.data;
                    in_ch.last_byte <= nxt.last;
                    in_ch.sender_ip <= nxt.sip;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Verdict receiver
    always @(posedge i_clk) begin : watch_verdicts
        t_verdict_rec want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: verdict transfer mismatch, expected none, actual %0d port %h",
                             $time, out_ch.verdict, out_ch.destination_port);
                    mismatches++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("verdict", 16'(want.verdict), 16'(out_ch.verdict));
                    check_field("entry_index", 16'(want.entry), 16'(out_ch.entry_index));
                    check_field("source_port", want.sport, out_ch.source_port);
                    check_field("destination_port", want.dport, out_ch.destination_port);
                    check_field("udp_length", want.len, out_ch.udp_length);
                end
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(rx_gaps_on && $urandom_range(99) < 12);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("udp_receive_check_and_port_demux verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [udp_rc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == udp_rc_pkg::CFG_LOCAL_IP) cfg_local_ip = val;
        else if (idx >= udp_rc_pkg::CFG_PORT_0 && idx <= udp_rc_pkg::CFG_PORT_LAST)
            cfg_entry[idx - udp_rc_pkg::CFG_PORT_0] = val[udp_rc_pkg::PORT_ENTRY_W-1:0];
    endtask

    task automatic load_settings(input logic [31:0] ip, input logic [16:0] e0,
                                 input logic [16:0] e1, input logic [16:0] e2,
                                 input logic [16:0] e3);
        logic [16:0] ent[udp_rc_pkg::PORT_STORE];
        ent = '{e0, e1, e2, e3};
        write_reg(udp_rc_pkg::CFG_LOCAL_IP, ip);
        // junk above bit 16 must be dropped
        for (int i = 0; i < udp_rc_pkg::PORT_STORE; i++)
            write_reg(udp_rc_pkg::CFG_IDX_W'(udp_rc_pkg::CFG_PORT_0 + i),
                      {15'($urandom()), ent[i]});
        write_reg(CFG_UNUSED_IDX, $urandom());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [16:0] rand_entry();
        return {1'($urandom_range(0, 3) != 0), 16'($urandom())};
    endfunction

    // Ones'-complement sum of pseudo header and the first span bytes of frame_bytes.
    function automatic logic [15:0] frame_sum(input int span, input logic [31:0] sip,
                                              input logic [15:0] len);
        logic [15:0] acc;
        acc = '0;
        for (int i = 0; i + 1 < span; i += 2)
            acc = oc16(acc, {frame_bytes[i], frame_bytes[i+1]});
        if (span % 2 != 0) acc = oc16(acc, {frame_bytes[span-1], 8'h00});
        acc = oc16(acc, sip[31:16]);
        acc = oc16(acc, sip[15:0]);
        acc = oc16(acc, cfg_local_ip[31:16]);
        acc = oc16(acc, cfg_local_ip[15:0]);
        acc = oc16(acc, udp_rc_pkg::UDP_PROTO);
        return oc16(acc, len);
    endfunction

    task automatic queue_datagram(input logic [15:0] sport, input logic [15:0] dport,
                                  input logic [15:0] len, input int nbytes,
                                  input t_sum_style style, input bit drain);
        logic [31:0] sip;
        logic [15:0] calc;
        logic [15:0] sent;
        int          span;
        t_byte_xfer  x;
        sip = $urandom();
        frame_bytes.delete();
        for (int i = 0; i < ((nbytes < 8) ? 8 : nbytes); i++)
            frame_bytes.push_back(8'($urandom()));
        {frame_bytes[0], frame_bytes[1]} = sport;
        {frame_bytes[2], frame_bytes[3]} = dport;
        {frame_bytes[4], frame_bytes[5]} = len;
        frame_bytes[6] = 8'h00;
        frame_bytes[7] = 8'h00;
        span = (int'(len) < nbytes) ? int'(len) : nbytes;
        if (style == SUM_FOLDS_TO_ZERO && span >= 10 && span % 2 == 0) begin
            // last data word cancels the rest, so the computed checksum folds to zero
            frame_bytes[span-2] = 8'h00;
            frame_bytes[span-1] = 8'h00;
            {frame_bytes[span-2], frame_bytes[span-1]} = ~frame_sum(span, sip, len);
        end
        calc = ~frame_sum(span, sip, len);
        if (calc == 16'd0) calc = 16'hFFFF;
        case (style)
            SUM_NONE: sent = 16'd0;
            SUM_BAD: begin
                do sent = 16'($urandom()); while (sent == 16'd0 || sent == calc);
            end
            default: sent = calc;
        endcase
        if (nbytes >= 8) {frame_bytes[6], frame_bytes[7]} = sent;
        for (int i = 0; i < nbytes; i++) begin
            x.data  = frame_bytes[i];
            x.last  = (i == nbytes - 1);
            x.sip   = (i == 0) ? sip : $urandom();
            x.drain = drain && (i == 0);
            byte_backlog.push_back(x);
        end
        bytes_queued += nbytes;
    endtask

    function automatic logic [15:0] listened_port();
        return cfg_entry[$urandom_range(0, udp_rc_pkg::PORT_STORE - 1)][15:0];
    endfunction

    task automatic queue_random_datagram(input bit drain);
        int          pick;
        int          body;
        logic [15:0] sport;
        logic [15:0] len;
        pick  = $urandom_range(99);
        body  = $urandom_range(8, 30);
        sport = 16'($urandom());
        if (pick < 40) begin
            queue_datagram(sport, listened_port(), 16'(body), body, SUM_GOOD, drain);
        end else if (pick < 48) begin
            queue_datagram(sport, 16'($urandom()), 16'(body), body, SUM_GOOD, drain);
        end else if (pick < 56) begin
            queue_datagram(sport, listened_port(), 16'(body), body, SUM_NONE, drain);
        end else if (pick < 64) begin
            queue_datagram(sport, listened_port(), 16'(body), body, SUM_BAD, drain);
        end else if (pick < 68) begin
            body = 2 * $urandom_range(5, 15);
            queue_datagram(sport, listened_port(), 16'(body), body, SUM_FOLDS_TO_ZERO, drain);
        end else if (pick < 75) begin
            // ends inside the header
            queue_datagram(sport, listened_port(), 16'(body), $urandom_range(1, 7),
                           SUM_GOOD, drain);
        end else if (pick < 82) begin
            len = 16'($urandom_range(0, 7));
            queue_datagram(sport, listened_port(), len, body, SUM_GOOD, drain);
        end else if (pick < 90) begin
            len = (pick == 89) ? 16'hFFFF : 16'(body + $urandom_range(1, 12));
            queue_datagram(sport, listened_port(), len, body, SUM_GOOD, drain);
        end else begin
            // trailing bytes past the length field
            queue_datagram(sport, listened_port(), 16'(body), body + $urandom_range(1, 6),
                           SUM_GOOD, drain);
        end
    endtask

    task automatic run_traffic(input int target, input int drain_at);
        int start;
        int n;
        start = bytes_queued;
        n     = 0;
        while (bytes_queued - start < target) begin
            queue_random_datagram(n == drain_at);
            n++;
        end
    endtask

    task automatic settle();
        while (bytes_taken != bytes_queued || pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] p;
        logic [15:0] q;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        in_ch.sender_ip = '0;
        out_ch.ready    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: header extremes, one-byte datagram, odd length pad,
        // invalid entry skipped, computed checksum of zero
        load_settings(32'hFFFF_FFFF, {1'b1, 16'h0000}, {1'b1, 16'hFFFF},
                      {1'b0, 16'h1234}, {1'b1, 16'h1234});
        queue_datagram(16'hFFFF, 16'hFFFF, 16'd8, 8, SUM_GOOD, 0);
        queue_datagram(16'h0000, 16'h0000, 16'd8, 1, SUM_GOOD, 0);
        queue_datagram(16'h0000, 16'h1234, 16'd9, 9, SUM_GOOD, 0);
        queue_datagram(16'h8001, 16'h0000, 16'd10, 10, SUM_FOLDS_TO_ZERO, 0);
        settle();

        load_settings($urandom(), rand_entry(), rand_entry(), rand_entry(), rand_entry());
        run_traffic(PHASE_BYTES, -1);
        settle();

        // back-to-back stretch, both sides
        tx_gaps_on = 0;
        rx_gaps_on = 0;
        load_settings(32'h0, 17'h0, 17'h0, 17'h0, {1'b1, 16'hFFFF});
        run_traffic(PHASE_BYTES, -1);
        settle();
        tx_gaps_on = 1;
        rx_gaps_on = 1;

        // duplicate ports: lower valid entry wins; long receiver stall
        p = 16'($urandom());
        q = 16'($urandom());
        load_settings($urandom(), {1'b1, p}, {1'b0, q}, {1'b1, p}, {1'b1, q});
        hold_request = 1;
        run_traffic(PHASE_BYTES, -1);
        settle();

        load_settings($urandom(), rand_entry(), rand_entry(), rand_entry(), rand_entry());
        run_traffic(PHASE_BYTES, 6);
        settle();

        load_settings($urandom(), rand_entry(), rand_entry(), rand_entry(), rand_entry());
        run_traffic(PHASE_BYTES, -1);
        settle();

        // directed delivery to a listening entry, then short random traffic
        p = 16'($urandom());
        load_settings($urandom(), rand_entry(), {1'b1, p}, rand_entry(), rand_entry());
        queue_datagram(16'($urandom()), p, 16'd24, 24, SUM_GOOD, 0);
        run_traffic(60, -1);
        settle();

        if (mismatches == 0) begin
            $display("udp_receive_check_and_port_demux verification clean");
        end else begin
            $display("udp_receive_check_and_port_demux verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/udp_rc_pkg.sv
hw/rtl/udp_rc_in_if.sv
hw/rtl/udp_rc_out_if.sv
hw/rtl/udp_rc_accum.sv
hw/rtl/udp_rc_verdict.sv
hw/rtl/udp_receive_check_and_port_demux.sv
sim/testbench.sv
